@@ rtl/core/mcr_pkg.sv @@
// Shared constants and types for the menu cursor key-repeat block.
`default_nettype none

package mcr_pkg;

    // Largest list length that the cursor logic honours.
    localparam logic [7:0] LIST_LIMIT = 8'd255;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ENTRY_COUNT   = 3'd0;
    localparam logic [2:0] CFG_INITIAL_DELAY = 3'd1;
    localparam logic [2:0] CFG_REPEAT_DELAY  = 3'd2;
    localparam logic [2:0] CFG_PAGE_STEP     = 3'd3;
    localparam logic [2:0] CFG_VISIBLE_LINES = 3'd4;

    // Configuration reset values.
    localparam logic [7:0] RST_ENTRY_COUNT   = 8'd0;
    localparam logic [7:0] RST_INITIAL_DELAY = 8'd14;
    localparam logic [7:0] RST_REPEAT_DELAY  = 8'd2;
    localparam logic [7:0] RST_PAGE_STEP     = 8'd11;
    localparam logic [7:0] RST_VISIBLE_LINES = 8'd12;

    // Direction bit positions.
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    // Configuration bundle handed to the working modules.
    typedef struct packed {
        logic [7:0] entry_count;
        logic [7:0] initial_delay;
        logic [7:0] repeat_delay;
        logic [7:0] page_step;
        logic [7:0] visible_lines;
    } mcr_cfg_t;

    // Result of the cursor update for one beat.
    typedef struct packed {
        logic [7:0] cursor_line;
        logic [7:0] top_line;
        logic       preview_cancel;
    } mcr_result_t;

endpackage

`default_nettype wire

@@ rtl/core/mcr_repeat.sv @@
// Per-direction auto-repeat counters and their fire decisions.
`default_nettype none

module mcr_repeat
    import mcr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [3:0] levels,
    input  wire mcr_cfg_t   cfg,
    output logic      [3:0] fire
);

    logic [3:0] last_levels_reg;
    logic [3:0] last_levels_next;
    logic [7:0] count_reg [4];
    logic [7:0] count_next [4];
    logic [7:0] limit_reg [4];
    logic [7:0] limit_next [4];

    // Edge detection, counter update and fire decision for each direction.
    always_comb
    begin
        logic [3:0] edges;
        logic [7:0] cnt;
        logic [7:0] lim;
        edges = levels ^ last_levels_reg;
        last_levels_next = levels;
        for (int d = 0; d < 4; d++)
        begin
            cnt = count_reg[d];
            lim = limit_reg[d];
            if (edges[d])
            begin
                cnt = 8'd0;
                lim = cfg.initial_delay;
            end
            if (levels[d])
            begin
                cnt = cnt + 8'd1;
                if (cnt > lim)
                begin
                    cnt = 8'd1;
                    lim = cfg.repeat_delay;
                end
            end
            count_next[d] = cnt;
            limit_next[d] = lim;
            fire[d] = (cnt == 8'd1);
        end
    end

    // State advances only when a beat moves through the update stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_levels_reg <= 4'd0;
            for (int d = 0; d < 4; d++)
            begin
                count_reg[d] <= 8'd0;
                limit_reg[d] <= 8'd0;
            end
        end
        else if (advance)
        begin
            last_levels_reg <= last_levels_next;
            for (int d = 0; d < 4; d++)
            begin
                count_reg[d] <= count_next[d];
                limit_reg[d] <= limit_next[d];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mcr_cursor.sv @@
// Cursor movement, list clamping and scroll window tracking.
`default_nettype none

module mcr_cursor
    import mcr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [3:0] fire,
    input  wire logic       clear,
    input  wire mcr_cfg_t   cfg,
    output mcr_result_t     result
);

    logic [7:0] cursor_reg;
    logic [7:0] cursor_next;
    logic [7:0] top_reg;
    logic [7:0] top_next;

    // Apply up, down, right and left in that order, then follow with the window.
    always_comb
    begin
        logic [7:0] n;
        logic [8:0] last;
        logic [8:0] cur;
        logic [8:0] vis;
        logic [8:0] top;
        logic       cancel;
        n = (cfg.entry_count > LIST_LIMIT) ? LIST_LIMIT : cfg.entry_count;
        last = {1'b0, n} - 9'd1;
        cur = {1'b0, cursor_reg};
        cancel = 1'b0;

        if (fire[DIR_UP] && cur != 9'd0)
        begin
            cur = cur - 9'd1;
            cancel = 1'b1;
        end
        if (fire[DIR_DOWN] && n != 8'd0 && cur < last)
        begin
            cur = cur + 9'd1;
            cancel = 1'b1;
        end
        if (fire[DIR_RIGHT])
        begin
            cancel = 1'b1;
            if (n == 8'd0)
                cur = 9'd0;
            else
            begin
                cur = cur + {1'b0, cfg.page_step};
                if (cur > last)
                    cur = last;
            end
        end
        if (fire[DIR_LEFT])
        begin
            cancel = 1'b1;
            if (n == 8'd0 || cur < {1'b0, cfg.page_step})
                cur = 9'd0;
            else
            begin
                cur = cur - {1'b0, cfg.page_step};
                if (cur > last)
                    cur = 9'd0;
            end
        end

        // A window of zero lines behaves as a single line.
        vis = (cfg.visible_lines == 8'd0) ? 9'd1 : {1'b0, cfg.visible_lines};
        top = {1'b0, top_reg};
        if (cur < top)
            top = cur;
        else if (cur >= top + vis)
            top = cur - (vis - 9'd1);

        if (clear)
        begin
            cur = 9'd0;
            top = 9'd0;
        end

        cursor_next = cur[7:0];
        top_next = top[7:0];
        result.cursor_line = cur[7:0];
        result.top_line = top[7:0];
        result.preview_cancel = cancel;
    end

    // Cursor and top line advance together with the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= 8'd0;
            top_reg <= 8'd0;
        end
        else if (advance)
        begin
            cursor_reg <= cursor_next;
            top_reg <= top_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/menu_cursor_key_repeat.sv @@
// Top level of the menu cursor key-repeat block with stream ports.
`default_nettype none

// Menu cursor with per-direction auto-repeat. Each input beat is one frame
// tick carrying four direction levels and a clear flag; each produces exactly
// one output beat with the cursor line, the top line of the scroll window and
// a preview-cancel flag. A beat is captured in an input register at the edge
// that accepts it, passes through the repeat counters and cursor logic into
// the output register once that register is free or being emptied, and
// leaves when the output side is not stalled. One beat is accepted every
// cycle while the output side is not stalled; the counter and cursor logic
// between the two registers is combinational. Input is taken while a
// finished result waits if the input register is empty. Configuration must
// be written only while no beat is in flight; the block does not enforce it.

module menu_cursor_key_repeat
    import mcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] up_held, [1] down_held, [2] left_held, [3] right_held,
    // [4] clear_cursor, [7:5] zero
    input  wire logic [7:0]  s_tdata,
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] cursor_line, [15:8] top_line, [16] preview_cancel, [23:17] zero
    output logic [23:0]      m_tdata
);

    mcr_cfg_t    cfg_reg;
    logic        in_valid_reg;
    logic [4:0]  in_data_reg;
    logic        out_valid_reg;
    mcr_result_t out_data_reg;
    logic        advance;
    logic [3:0]  fire;
    mcr_result_t result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count   <= RST_ENTRY_COUNT;
            cfg_reg.initial_delay <= RST_INITIAL_DELAY;
            cfg_reg.repeat_delay  <= RST_REPEAT_DELAY;
            cfg_reg.page_step     <= RST_PAGE_STEP;
            cfg_reg.visible_lines <= RST_VISIBLE_LINES;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT:   cfg_reg.entry_count   <= cfg_data;
                CFG_INITIAL_DELAY: cfg_reg.initial_delay <= cfg_data;
                CFG_REPEAT_DELAY:  cfg_reg.repeat_delay  <= cfg_data;
                CFG_PAGE_STEP:     cfg_reg.page_step     <= cfg_data;
                CFG_VISIBLE_LINES: cfg_reg.visible_lines <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A beat moves on when the output register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata[4:0];
    end

    mcr_repeat u_repeat (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .levels  (in_data_reg[3:0]),
        .cfg     (cfg_reg),
        .fire    (fire)
    );

    mcr_cursor u_cursor (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .fire    (fire),
        .clear   (in_data_reg[4]),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.preview_cancel,
                       out_data_reg.top_line, out_data_reg.cursor_line};

endmodule

`default_nettype wire

@@ rtl/core/mcr_checker.sv @@
// Port-level checks for the menu cursor key-repeat block, bound to the top level.
`default_nettype none

module mcr_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata
);

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // The window never starts below the cursor.
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:8] <= m_tdata[7:0])
        else $error("top line beyond cursor line");

    // The cursor and the top line stay inside the largest possible list.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] != 8'd255 && m_tdata[15:8] != 8'd255)
        else $error("cursor or top line out of range");

    // Padding bits of a result beat stay clear.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:17] == 7'd0)
        else $error("result padding not zero");

endmodule

bind menu_cursor_key_repeat mcr_checker u_mcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
